@@ rtl/core/three_rod_inverse_kinematics_unit_assert.svh @@
// assertion macros for the three-rod inverse kinematics unit
// no dependencies; empty bodies when SYNTH is defined
`ifndef THREE_ROD_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`define THREE_ROD_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TRIK_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("trik assertion failed");
`define TRIK_ASSERT_IMP(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("trik assertion failed");
`else
`define TRIK_ASSERT(name, clk, rstn, prop)
`define TRIK_ASSERT_IMP(name, clk, rstn, pre, post)
`endif
`endif

@@ rtl/core/trik_pkg.sv @@
// types, constants and arithmetic helpers for the three-rod inverse kinematics unit
// no dependencies
`default_nettype none

package trik_pkg;

  localparam int POS_FRAC_BITS = 12;
  localparam int POS_W         = 24;
  localparam int PIV_W         = 20;
  localparam int PIV_FRAC      = 12;
  localparam int DIST_FRAC     = 20;
  localparam int SCALE_FRAC    = 8;
  localparam int SCALE_W       = 24;
  localparam int ROT_SC_W      = 20;
  localparam int REG_W         = 60;
  localparam int OUT_W         = 40;
  localparam int OFS_W         = 32;

  localparam int PIV_LSH   = (POS_FRAC_BITS >= PIV_FRAC) ? POS_FRAC_BITS - PIV_FRAC : 0;
  localparam int PIV_RSH   = (POS_FRAC_BITS < PIV_FRAC) ? PIV_FRAC - POS_FRAC_BITS : 0;
  localparam int PIV_RHALF = (PIV_RSH > 0) ? (1 << (PIV_RSH - 1)) : 0;
  localparam int APW       = PIV_W + PIV_LSH;
  localparam int DW        = ((POS_W > APW) ? POS_W : APW) + 1;
  localparam int SW        = 2 * DW;
  localparam int SQ_SH     = 2 * DIST_FRAC - 2 * POS_FRAC_BITS;
  localparam int RW        = SW + SQ_SH;
  localparam int RB        = RW / 2;
  localparam int REMW      = RB + 3;
  localparam int SQ_PER    = 2;
  localparam int SQS       = (RB + SQ_PER - 1) / SQ_PER;
  localparam int DFW       = ((RB + 1 > OFS_W) ? RB + 1 : OFS_W) + 1;
  localparam int HIW       = DFW - 20 + SCALE_W + 1;
  localparam int NST       = SQS + 7;
  localparam int ROT_PW    = POS_W + ROT_SC_W + 1;
  localparam int ROT_SH    = POS_FRAC_BITS + SCALE_FRAC;
  localparam int ROD_SH    = DIST_FRAC + SCALE_FRAC;

  localparam logic [REG_W-1:0]   PIVOT0_RST = 60'd54043195528445952;
  localparam logic [REG_W-1:0]   PIVOT1_RST = 60'd51539607552;
  localparam logic [REG_W-1:0]   PIVOT2_RST = 60'd49539608786026496;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd256;
  localparam logic [REG_W-1:0]   ROT_SC_RST = 60'd281475245146368;

  localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
  localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

  typedef enum logic [2:0] {
    REG_PIVOT0     = 3'd0,
    REG_PIVOT1     = 3'd1,
    REG_PIVOT2     = 3'd2,
    REG_SCALE0     = 3'd3,
    REG_SCALE1     = 3'd4,
    REG_SCALE2     = 3'd5,
    REG_ROT_SCALES = 3'd6
  } trik_reg_e;

  typedef enum logic [1:0] {
    OFS_IDLE,
    OFS_SQUARE,
    OFS_ROOT,
    OFS_DONE
  } trik_ofs_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] rot_a;
    logic signed [POS_W-1:0] rot_b;
    logic signed [POS_W-1:0] rot_c;
  } trik_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] act0;
    logic signed [OUT_W-1:0] act1;
    logic signed [OUT_W-1:0] act2;
    logic signed [OUT_W-1:0] act3;
    logic signed [OUT_W-1:0] act4;
    logic signed [OUT_W-1:0] act5;
  } trik_out_t;

  typedef struct packed {
    logic [RW-1:0]   rad;
    logic [REMW-1:0] rem;
    logic [RB-1:0]   root;
  } trik_sq_t;

  // one restoring square root step, two radicand bits in, one root bit out
  function automatic trik_sq_t trik_sq_step(trik_sq_t a);
    trik_sq_t        r;
    logic [REMW-1:0] rem_s;
    logic [REMW-1:0] trial;
    rem_s = {a.rem[REMW-3:0], a.rad[RW-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = {a.rad[RW-3:0], 2'b00};
    if (rem_s >= trial) begin
      r.rem  = rem_s - trial;
      r.root = {a.root[RB-2:0], 1'b1};
    end else begin
      r.rem  = rem_s;
      r.root = {a.root[RB-2:0], 1'b0};
    end
    return r;
  endfunction

  // round to nearest, ties away from zero, then clamp to the output range
  function automatic logic signed [OUT_W-1:0] trik_rnd_sat(logic signed [63:0] v,
                                                           int unsigned sh);
    logic              neg;
    logic [63:0]       m;
    logic signed [63:0] r;
    neg = v[63];
    m   = neg ? 64'(-v) : 64'(v);
    m   = (m + (64'd1 << (sh - 1))) >> sh;
    r   = neg ? -$signed(m) : $signed(m);
    if (r > OUT_MAX) r = OUT_MAX;
    else if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  // pivot coordinate brought to the position fraction width
  function automatic logic signed [APW-1:0] trik_align(logic signed [PIV_W-1:0] p);
    logic              neg;
    logic [PIV_W:0]    m;
    logic signed [APW-1:0] r;
    neg = p[PIV_W-1];
    m   = neg ? (PIV_W + 1)'(-(PIV_W + 1)'(p)) : (PIV_W + 1)'(p);
    if (PIV_RSH == 0) begin
      r = APW'(p);
      r = r <<< PIV_LSH;
    end else begin
      m = (m + (PIV_W + 1)'(PIV_RHALF)) >> PIV_RSH;
      r = neg ? -APW'(m) : APW'(m);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/three_rod_inverse_kinematics_unit.sv @@
// throughput: one request per cycle unless an offset refresh or out_stall_i stalls the input
// pipeline depth is set by the pipelined rod square roots
// rod offsets come from a one-bit-a-cycle square root unit
// after reset, and after every pivot write, input stalls while offsets refresh
// async active-low reset clears valids and the offset sequencer and loads config reset values
`default_nettype none
`include "three_rod_inverse_kinematics_unit_assert.svh"

module three_rod_inverse_kinematics_unit
  import trik_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire trik_in_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output trik_out_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [REG_W-1:0]   cfg_data_i
);

  localparam int OFS_STEPS = 28;
  localparam int S_R1 = 3 + SQS;
  localparam int S_R2 = 4 + SQS;
  localparam int S_R3 = 5 + SQS;
  localparam int S_R4 = 6 + SQS;

  logic [REG_W-1:0]   pivot_q [3];
  logic [SCALE_W-1:0] scale_q [3];
  logic [REG_W-1:0]   rot_sc_q;
  logic [OFS_W-1:0]   offset_q [3];

  trik_ofs_e    ofs_state_q, ofs_state_d;
  logic [1:0]   ofs_rod_q, ofs_rod_d;
  logic [4:0]   ofs_cnt_q, ofs_cnt_d;
  logic [55:0]  ofs_rad_q, ofs_rad_d;
  logic [30:0]  ofs_rem_q, ofs_rem_d;
  logic [27:0]  ofs_root_q, ofs_root_d;
  logic [2:0]   pend_q, pend_set, pend_clr;
  logic         ofs_busy;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  logic           in_acc;

  logic signed [DW-1:0]     d_q [3][3];
  logic signed [DW-1:0]     d_d [3][3];
  logic signed [ROT_PW-1:0] rot_prod_q [3];
  logic signed [ROT_PW-1:0] rot_prod_d [3];
  logic [SW-1:0]            sqr_q [3][3];
  logic [SW-1:0]            s_q [3];
  trik_sq_t                 sq_src [SQS][3];
  trik_sq_t                 sq_nxt [SQS][3];
  trik_sq_t                 sq_q [SQS][3];
  logic signed [DFW-1:0]    diff_q [3];
  logic [43:0]              plo_q [3];
  logic signed [HIW-1:0]    phi_q [3];
  logic signed [63:0]       prod_q [3];
  logic signed [OUT_W-1:0]  act_q [3];
  logic signed [OUT_W-1:0]  rot_q [1:NST-1][3];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q[0] <= PIVOT0_RST;
      pivot_q[1] <= PIVOT1_RST;
      pivot_q[2] <= PIVOT2_RST;
      for (int r = 0; r < 3; r++) scale_q[r] <= SCALE_RST;
      rot_sc_q <= ROT_SC_RST;
    end else if (cfg_we_i) begin
      case (trik_reg_e'(cfg_idx_i))
        REG_PIVOT0:     pivot_q[0] <= cfg_data_i;
        REG_PIVOT1:     pivot_q[1] <= cfg_data_i;
        REG_PIVOT2:     pivot_q[2] <= cfg_data_i;
        REG_SCALE0:     scale_q[0] <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE1:     scale_q[1] <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE2:     scale_q[2] <= cfg_data_i[SCALE_W-1:0];
        REG_ROT_SCALES: rot_sc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pend_set = '0;
    if (cfg_we_i) begin
      case (trik_reg_e'(cfg_idx_i))
        REG_PIVOT0: pend_set = 3'b001;
        REG_PIVOT1: pend_set = 3'b010;
        REG_PIVOT2: pend_set = 3'b100;
        default:    pend_set = '0;
      endcase
    end
  end

  // rod offset sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_state_q <= OFS_IDLE;
      ofs_rod_q   <= '0;
      ofs_cnt_q   <= '0;
      pend_q      <= 3'b111;
    end else begin
      ofs_state_q <= ofs_state_d;
      ofs_rod_q   <= ofs_rod_d;
      ofs_cnt_q   <= ofs_cnt_d;
      pend_q      <= (pend_q & ~pend_clr) | pend_set;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_rad_q  <= ofs_rad_d;
    ofs_rem_q  <= ofs_rem_d;
    ofs_root_q <= ofs_root_d;
    if (ofs_state_q == OFS_DONE) begin
      offset_q[ofs_rod_q] <= OFS_W'(ofs_root_q) + OFS_W'(ofs_rem_q > 31'(ofs_root_q));
    end
  end

  always_comb begin
    logic signed [PIV_W-1:0] p;
    logic signed [39:0]      pp;
    logic [41:0]             s;
    logic [30:0]             rem_s;
    logic [30:0]             trial;
    ofs_state_d = ofs_state_q;
    ofs_rod_d   = ofs_rod_q;
    ofs_cnt_d   = ofs_cnt_q;
    ofs_rad_d   = ofs_rad_q;
    ofs_rem_d   = ofs_rem_q;
    ofs_root_d  = ofs_root_q;
    pend_clr    = '0;
    s           = '0;
    p           = '0;
    pp          = '0;
    rem_s       = {ofs_rem_q[28:0], ofs_rad_q[55:54]};
    trial       = {1'b0, ofs_root_q, 2'b01};
    case (ofs_state_q)
      OFS_IDLE: begin
        if (pend_q[0]) begin
          ofs_rod_d = 2'd0;
          pend_clr  = 3'b001;
          ofs_state_d = OFS_SQUARE;
        end else if (pend_q[1]) begin
          ofs_rod_d = 2'd1;
          pend_clr  = 3'b010;
          ofs_state_d = OFS_SQUARE;
        end else if (pend_q[2]) begin
          ofs_rod_d = 2'd2;
          pend_clr  = 3'b100;
          ofs_state_d = OFS_SQUARE;
        end
      end
      OFS_SQUARE: begin
        for (int k = 0; k < 3; k++) begin
          p  = pivot_q[ofs_rod_q][REG_W-1-PIV_W*k -: PIV_W];
          pp = 40'(p);
          s  = s + 42'($unsigned(pp * pp));
        end
        ofs_rad_d   = {s[39:0], 16'b0};
        ofs_rem_d   = '0;
        ofs_root_d  = '0;
        ofs_cnt_d   = '0;
        ofs_state_d = OFS_ROOT;
      end
      OFS_ROOT: begin
        ofs_rad_d = {ofs_rad_q[53:0], 2'b00};
        if (rem_s >= trial) begin
          ofs_rem_d  = rem_s - trial;
          ofs_root_d = {ofs_root_q[26:0], 1'b1};
        end else begin
          ofs_rem_d  = rem_s;
          ofs_root_d = {ofs_root_q[26:0], 1'b0};
        end
        ofs_cnt_d = ofs_cnt_q + 5'd1;
        if (ofs_cnt_q == 5'(OFS_STEPS - 1)) ofs_state_d = OFS_DONE;
      end
      OFS_DONE: ofs_state_d = OFS_IDLE;
      default:  ofs_state_d = OFS_IDLE;
    endcase
  end

  assign ofs_busy = (ofs_state_q != OFS_IDLE) || (pend_q != '0);

  // pipeline handshake
  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_stall_o = ofs_busy || !en[0];
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_acc;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: coordinate differences and rotary products
  always_comb begin
    logic signed [POS_W-1:0] pos [3];
    logic signed [POS_W-1:0] rot [3];
    logic [ROT_SC_W-1:0]     sc;
    pos[0] = in_data_i.pos_x;
    pos[1] = in_data_i.pos_y;
    pos[2] = in_data_i.pos_z;
    rot[0] = in_data_i.rot_a;
    rot[1] = in_data_i.rot_b;
    rot[2] = in_data_i.rot_c;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        d_d[r][k] = DW'(pos[k])
                  - DW'(trik_align(pivot_q[r][REG_W-1-PIV_W*k -: PIV_W]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      sc = rot_sc_q[REG_W-1-ROT_SC_W*k -: ROT_SC_W];
      rot_prod_d[k] = ROT_PW'(rot[k]) * $signed({1'b0, sc});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_q        <= d_d;
      rot_prod_q <= rot_prod_d;
    end
  end

  // stage 2: squares, rotary rounding
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] dx;
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          dx = SW'(d_q[r][k]);
          sqr_q[r][k] <= $unsigned(dx * dx);
        end
      end
      for (int k = 0; k < 3; k++) begin
        rot_q[1][k] <= trik_rnd_sat(64'(rot_prod_q[k]), ROT_SH);
      end
    end
  end

  // stage 3: sums of squares
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) s_q[r] <= sqr_q[r][0] + sqr_q[r][1] + sqr_q[r][2];
    end
  end

  // square root stages
  for (genvar j = 0; j < SQS; j++) begin : g_sq
    if (j == 0) begin : g_first
      always_comb begin
        for (int r = 0; r < 3; r++) begin
          sq_src[0][r].rad  = RW'(s_q[r]) << SQ_SH;
          sq_src[0][r].rem  = '0;
          sq_src[0][r].root = '0;
        end
      end
    end else begin : g_next
      assign sq_src[j] = sq_q[j-1];
    end

    always_comb begin
      trik_sq_t t;
      for (int r = 0; r < 3; r++) begin
        t = sq_src[j][r];
        for (int i = 0; i < SQ_PER; i++) begin
          if (j * SQ_PER + i < RB) t = trik_sq_step(t);
        end
        sq_nxt[j][r] = t;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[3+j]) sq_q[j] <= sq_nxt[j];
    end
  end

  // rounding of the root and rod difference
  always_ff @(posedge clk_i) begin
    logic [RB:0] rootr;
    if (en[S_R1]) begin
      for (int r = 0; r < 3; r++) begin
        rootr = (RB + 1)'(sq_q[SQS-1][r].root)
              + (RB + 1)'(sq_q[SQS-1][r].rem > REMW'(sq_q[SQS-1][r].root));
        diff_q[r] <= $signed(DFW'(rootr)) - $signed(DFW'(offset_q[r]));
      end
    end
  end

  // partial products with the rod scale
  always_ff @(posedge clk_i) begin
    if (en[S_R2]) begin
      for (int r = 0; r < 3; r++) begin
        plo_q[r] <= diff_q[r][19:0] * scale_q[r];
        phi_q[r] <= HIW'($signed(diff_q[r][DFW-1:20])) * $signed({1'b0, scale_q[r]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] hi_ext;
    if (en[S_R3]) begin
      for (int r = 0; r < 3; r++) begin
        hi_ext    = 64'(phi_q[r]);
        prod_q[r] <= (hi_ext <<< 20) + $signed(64'(plo_q[r]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_R4]) begin
      for (int r = 0; r < 3; r++) act_q[r] <= trik_rnd_sat(prod_q[r], ROD_SH);
    end
  end

  // rotary results ride along
  for (genvar k = 2; k < NST; k++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en[k]) rot_q[k] <= rot_q[k-1];
    end
  end

  assign out_valid_o     = v_q[NST-1];
  assign out_data_o.act0 = act_q[0];
  assign out_data_o.act1 = act_q[1];
  assign out_data_o.act2 = act_q[2];
  assign out_data_o.act3 = rot_q[NST-1][0];
  assign out_data_o.act4 = rot_q[NST-1][1];
  assign out_data_o.act5 = rot_q[NST-1][2];

  `TRIK_ASSERT_IMP(a_acc_fills_first, clk_i, rst_ni, in_acc, ##1 v_q[0])
  `TRIK_ASSERT_IMP(a_no_acc_busy, clk_i, rst_ni, ofs_state_q != OFS_IDLE, !in_acc)
  `TRIK_ASSERT_IMP(a_done_to_idle, clk_i, rst_ni, ofs_state_q == OFS_DONE, ##1 ofs_state_q == OFS_IDLE)
  `TRIK_ASSERT_IMP(a_root_cnt, clk_i, rst_ni, ofs_state_q == OFS_ROOT, ofs_cnt_q < 5'(OFS_STEPS))

endmodule

`default_nettype wire
